FILE: sv/acp_pkg.sv
// Shared types and constants for the alignment column profile block.
// No dependencies; used by acp_count, acp_score and the top level.
`default_nettype none

package acp_pkg;

  localparam int unsigned NumClasses     = 6;
  localparam int unsigned NonBlankCls    = 5;
  localparam int unsigned CntW           = 8;
  localparam int unsigned ClsW           = 3;
  localparam int unsigned DepthW         = 11;
  localparam int unsigned TotalW         = 24;
  localparam int unsigned MaxDepth       = 255;
  localparam int unsigned MinScoredDepth = 4;
  localparam int unsigned CntLimitInt    = (MaxDepth < 255) ? MaxDepth : 255;

  localparam logic [CntW-1:0]   CntLimit  = CntW'(CntLimitInt);
  localparam logic [CntW-1:0]   ByteLimit = 8'hFF;
  localparam logic [DepthW-1:0] MinScored = DepthW'(MinScoredDepth);

  typedef enum logic [2:0] {
    BaseA     = 3'd0,
    BaseC     = 3'd1,
    BaseG     = 3'd2,
    BaseT     = 3'd3,
    BaseGap   = 3'd4,
    BaseBlank = 3'd5,
    BaseN     = 3'd6,
    BaseIgn   = 3'd7
  } base_e;

  localparam logic [ClsW-1:0] ClsBlank = 3'd5;

  typedef logic [CntW-1:0] cnt_t;
  typedef cnt_t [NumClasses-1:0] cnt_arr_t;

  typedef struct packed {
    logic [ClsW-1:0]   majority;
    logic [CntW-1:0]   mismatch;
    logic [DepthW-1:0] saved_raw;
    logic              scored;
  } score_t;

  typedef struct packed {
    logic            hit;
    logic [ClsW-1:0] cls;
  } cls_sel_t;

  function automatic cls_sel_t class_of(input logic [2:0] code);
    cls_sel_t r;
    r.hit = 1'b1;
    r.cls = code;
    unique case (base_e'(code))
      BaseA, BaseC, BaseG, BaseT, BaseGap: r.cls = code;
      BaseBlank, BaseN:                    r.cls = ClsBlank;
      default: begin
        r.hit = 1'b0;
        r.cls = '0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/acp_count.sv
// Per-column class counters with saturating increment and column clear.
// Depends on acp_pkg.
`default_nettype none

module acp_count (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              go_i,
  input  wire logic [2:0]        base_code_i,
  input  wire logic              row_marked_i,
  input  wire logic              column_end_i,
  output acp_pkg::cnt_arr_t      counts_o
);

  acp_pkg::cnt_arr_t cnt_q, cnt_d, upd;
  acp_pkg::cls_sel_t sel;

  always_comb begin
    sel = acp_pkg::class_of(base_code_i);
    upd = cnt_q;
    if (row_marked_i && sel.hit && (cnt_q[sel.cls] != acp_pkg::CntLimit)) begin
      upd[sel.cls] = cnt_q[sel.cls] + 8'd1;
    end
    cnt_d = cnt_q;
    if (go_i) begin
      cnt_d = column_end_i ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign counts_o = upd;

endmodule

`default_nettype wire

FILE: sv/acp_score.sv
// Column scoring: majority class, mismatch count and parsimony saved steps.
// Depends on acp_pkg.
`default_nettype none

module acp_score (
  input  wire acp_pkg::cnt_arr_t counts_i,
  output acp_pkg::score_t        score_o
);

  logic [acp_pkg::DepthW-1:0] depth, sum_terms, mism_w;
  logic [acp_pkg::CntW-1:0]   term, max_term;
  logic [acp_pkg::ClsW-1:0]   maj;

  always_comb begin
    depth     = '0;
    sum_terms = '0;
    max_term  = '0;
    maj       = '0;
    term      = '0;
    for (int k = 0; k < acp_pkg::NonBlankCls; k++) begin
      term      = (counts_i[k] != '0) ? counts_i[k] - 8'd1 : '0;
      depth     = depth + acp_pkg::DepthW'(counts_i[k]);
      sum_terms = sum_terms + acp_pkg::DepthW'(term);
      if (term > max_term) begin
        max_term = term;
      end
      if (counts_i[maj] < counts_i[k]) begin
        maj = acp_pkg::ClsW'(k);
      end
    end
    mism_w = depth - acp_pkg::DepthW'(counts_i[maj]);

    score_o.majority  = maj;
    score_o.mismatch  = (mism_w > acp_pkg::DepthW'(acp_pkg::ByteLimit)) ?
                        acp_pkg::ByteLimit : mism_w[acp_pkg::CntW-1:0];
    score_o.scored    = (depth >= acp_pkg::MinScored);
    score_o.saved_raw = score_o.scored ?
                        (sum_terms - acp_pkg::DepthW'(max_term)) : '0;
  end

endmodule

`default_nettype wire

FILE: sv/alignment_column_profile_parsimony.sv
// Top level: input register, counters, column scoring, run total, result register.
// Depends on acp_pkg, acp_count and acp_score.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+------------------------------------
//   in      | in_valid_i   | in_stall_o   | base_code, row_marked, column/region end
//   out     | out_valid_o  | out_stall_i  | six counts, majority, mismatch, steps
//
// One cell per cycle, unless a column end meets a stalled result.
// The rate is set by the counter update feeding the result register.
// Reset clears counters, run total and both valid flags.
// A stalled result holds; cells without column end keep flowing past it.
`default_nettype none

module alignment_column_profile_parsimony (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  base_code_i,
  input  wire logic        row_marked_i,
  input  wire logic        column_end_i,
  input  wire logic        region_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       count_adenine_o,
  output logic [7:0]       count_cytosine_o,
  output logic [7:0]       count_guanine_o,
  output logic [7:0]       count_thymine_o,
  output logic [7:0]       count_gap_o,
  output logic [7:0]       count_blank_o,
  output logic [2:0]       majority_class_o,
  output logic [7:0]       mismatch_count_o,
  output logic [7:0]       saved_steps_o,
  output logic             column_scored_o,
  output logic [23:0]      total_saved_steps_o,
  output logic             region_last_o
);

  logic        s1_valid_q, s1_valid_d;
  logic [2:0]  s1_code_q;
  logic        s1_marked_q, s1_col_q, s1_reg_q;
  logic        in_acc, s1_go, out_free, emit;

  logic [acp_pkg::TotalW-1:0] total_q, total_d, total_sat;
  logic [acp_pkg::TotalW:0]   total_sum;
  logic                       out_valid_q, out_valid_d;

  acp_pkg::cnt_arr_t counts;
  acp_pkg::score_t   score;

  acp_pkg::cnt_arr_t          r_cnt_q;
  acp_pkg::score_t            r_score_q;
  logic [acp_pkg::CntW-1:0]   r_saved_q;
  logic [acp_pkg::TotalW-1:0] r_total_q;
  logic                       r_last_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_col_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign emit       = s1_go && s1_col_q;

  acp_count u_count (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (s1_go),
    .base_code_i  (s1_code_q),
    .row_marked_i (s1_marked_q),
    .column_end_i (s1_col_q),
    .counts_o     (counts)
  );

  acp_score u_score (
    .counts_i (counts),
    .score_o  (score)
  );

  always_comb begin
    total_sum = {1'b0, total_q} + (acp_pkg::TotalW + 1)'(score.saved_raw);
    total_sat = total_sum[acp_pkg::TotalW] ? '1 : total_sum[acp_pkg::TotalW-1:0];
    total_d   = total_q;
    if (emit) begin
      total_d = s1_reg_q ? '0 : total_sat;
    end
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_code_q   <= base_code_i;
      s1_marked_q <= row_marked_i;
      s1_col_q    <= column_end_i;
      s1_reg_q    <= region_end_i;
    end
    if (emit) begin
      r_cnt_q   <= counts;
      r_score_q <= score;
      r_saved_q <= (score.saved_raw > acp_pkg::DepthW'(acp_pkg::ByteLimit)) ?
                   acp_pkg::ByteLimit : score.saved_raw[acp_pkg::CntW-1:0];
      r_total_q <= total_sat;
      r_last_q  <= s1_reg_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign count_adenine_o     = r_cnt_q[0];
  assign count_cytosine_o    = r_cnt_q[1];
  assign count_guanine_o     = r_cnt_q[2];
  assign count_thymine_o     = r_cnt_q[3];
  assign count_gap_o         = r_cnt_q[4];
  assign count_blank_o       = r_cnt_q[5];
  assign majority_class_o    = r_score_q.majority;
  assign mismatch_count_o    = r_score_q.mismatch;
  assign saved_steps_o       = r_saved_q;
  assign column_scored_o     = r_score_q.scored;
  assign total_saved_steps_o = r_total_q;
  assign region_last_o       = r_last_q;

endmodule

`default_nettype wire

FILE: tb/sv/acp_column_checker.sv
`timescale 1ns / 100ps
// Column profile checker: follows accepted cells, predicts every column result
// and compares it field by field with the returned result. Depends on acp_pkg.

module acp_column_checker
  import acp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire logic [2:0]        base_code_i,
  input  wire logic              row_marked_i,
  input  wire logic              column_end_i,
  input  wire logic              region_end_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic [CntW-1:0]   count_adenine_i,
  input  wire logic [CntW-1:0]   count_cytosine_i,
  input  wire logic [CntW-1:0]   count_guanine_i,
  input  wire logic [CntW-1:0]   count_thymine_i,
  input  wire logic [CntW-1:0]   count_gap_i,
  input  wire logic [CntW-1:0]   count_blank_i,
  input  wire logic [ClsW-1:0]   majority_class_i,
  input  wire logic [CntW-1:0]   mismatch_count_i,
  input  wire logic [CntW-1:0]   saved_steps_i,
  input  wire logic              column_scored_i,
  input  wire logic [TotalW-1:0] total_saved_steps_i,
  input  wire logic              region_last_i,
  output int unsigned            errors_o,
  output int unsigned            pending_o
);

  localparam int unsigned TotalMax = (1 << TotalW) - 1;

  typedef struct packed {
    cnt_arr_t          counts;
    logic [ClsW-1:0]   majority;
    logic [CntW-1:0]   mismatch;
    logic [CntW-1:0]   saved;
    logic              scored;
    logic [TotalW-1:0] total;
    logic              last;
  } column_result_t;

  string class_name [NumClasses] = '{"adenine", "cytosine", "guanine", "thymine",
                                     "gap", "blank"};

  cnt_t              class_tally [NumClasses];
  logic [TotalW-1:0] steps_total;
  column_result_t    expected_columns [$];
  int unsigned       error_count = 0;
  int unsigned       pending_count = 0;

  assign errors_o  = error_count;
  assign pending_o = pending_count;

  task automatic compare_field(input string name, input int unsigned want, got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic tally_cell(input logic [2:0] code);
    int unsigned cls;
    case (base_e'(code))
      BaseA, BaseC, BaseG, BaseT, BaseGap: cls = code;
      BaseBlank, BaseN:                    cls = ClsBlank;
      default:                             cls = NumClasses;
    endcase
    if (cls < NumClasses) begin
      if (class_tally[cls] < CntLimitInt) class_tally[cls]++;
    end
  endtask

  function automatic column_result_t close_column(input logic last);
    column_result_t r;
    int unsigned depth = 0;
    int unsigned sum_terms = 0;
    int unsigned max_term = 0;
    int unsigned term;
    int unsigned saved;
    int unsigned lead = 0;
    int unsigned next_total;
    int unsigned mism;
    for (int k = 0; k < NonBlankCls; k++) begin
      term = (class_tally[k] > 0) ? class_tally[k] - 1 : 0;
      depth += class_tally[k];
      sum_terms += term;
      if (term > max_term) max_term = term;
      if (class_tally[lead] < class_tally[k]) lead = k;
    end
    r.scored = depth >= MinScoredDepth;
    saved = r.scored ? sum_terms - max_term : 0;
    next_total = steps_total + saved;
    steps_total = TotalW'((next_total > TotalMax) ? TotalMax : next_total);
    for (int k = 0; k < NumClasses; k++) r.counts[k] = class_tally[k];
    r.majority = ClsW'(lead);
    mism = depth - class_tally[lead];
    r.mismatch = CntW'((mism > ByteLimit) ? ByteLimit : mism);
    r.saved = CntW'((saved > ByteLimit) ? ByteLimit : saved);
    r.total = steps_total;
    r.last = last;
    foreach (class_tally[k]) class_tally[k] = '0;
    if (last) steps_total = '0;
    return r;
  endfunction

  always @(posedge clk_i) begin
    column_result_t want;
    column_result_t got;
    if (!rst_ni) begin
      foreach (class_tally[k]) class_tally[k] = '0;
      steps_total = '0;
      expected_columns.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.counts[0] = count_adenine_i;
        got.counts[1] = count_cytosine_i;
        got.counts[2] = count_guanine_i;
        got.counts[3] = count_thymine_i;
        got.counts[4] = count_gap_i;
        got.counts[5] = count_blank_i;
        got.majority  = majority_class_i;
        got.mismatch  = mismatch_count_i;
        got.saved     = saved_steps_i;
        got.scored    = column_scored_i;
        got.total     = total_saved_steps_i;
        got.last      = region_last_i;
        if (expected_columns.size() == 0) begin
          error_count++;
          $display("%0t: column result expected none, actual total %0d", $time,
                   got.total);
        end else begin
          want = expected_columns.pop_front();
          for (int k = 0; k < NumClasses; k++) begin
            compare_field({"count_", class_name[k]}, want.counts[k], got.counts[k]);
          end
          compare_field("majority_class", want.majority, got.majority);
          compare_field("mismatch_count", want.mismatch, got.mismatch);
          compare_field("saved_steps", want.saved, got.saved);
          compare_field("column_scored", want.scored, got.scored);
          compare_field("total_saved_steps", want.total, got.total);
          compare_field("region_last", want.last, got.last);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (row_marked_i) tally_cell(base_code_i);
        if (column_end_i) expected_columns.push_back(close_column(region_end_i));
      end
    end
    pending_count = expected_columns.size();
  end

endmodule

FILE: tb/sv/alignment_column_profile_parsimony_tb.sv
`timescale 1ns / 100ps
// Testbench top: streams alignment cells into alignment_column_profile_parsimony with
// bursty requests and a random result stall. Depends on acp_pkg and acp_column_checker.

module alignment_column_profile_parsimony_tb;
  import acp_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemTarget = 950;

  typedef enum logic [1:0] {StallNone, StallLight, StallHalf, StallHeavy} stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [2:0] base_code_i = '0;
  logic row_marked_i = 1'b0;
  logic column_end_i = 1'b0;
  logic region_end_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [7:0] count_adenine_o, count_cytosine_o, count_guanine_o, count_thymine_o;
  logic [7:0] count_gap_o, count_blank_o, mismatch_count_o, saved_steps_o;
  logic [2:0] majority_class_o;
  logic column_scored_o, region_last_o;
  logic [23:0] total_saved_steps_o;

  int unsigned error_count;
  int unsigned pending_columns;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned cells_sent = 0;
  stall_mode_e stall_mode = StallNone;
  int unsigned stall_phase = 0;

  alignment_column_profile_parsimony u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .base_code_i, .row_marked_i,
    .column_end_i, .region_end_i, .out_valid_o, .out_stall_i, .count_adenine_o,
    .count_cytosine_o, .count_guanine_o, .count_thymine_o, .count_gap_o,
    .count_blank_o, .majority_class_o, .mismatch_count_o, .saved_steps_o,
    .column_scored_o, .total_saved_steps_o, .region_last_o
  );

  acp_column_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i          (in_stall_o),
    .base_code_i, .row_marked_i, .column_end_i, .region_end_i,
    .out_valid_i         (out_valid_o),
    .out_stall_i,
    .count_adenine_i     (count_adenine_o),
    .count_cytosine_i    (count_cytosine_o),
    .count_guanine_i     (count_guanine_o),
    .count_thymine_i     (count_thymine_o),
    .count_gap_i         (count_gap_o),
    .count_blank_i       (count_blank_o),
    .majority_class_i    (majority_class_o),
    .mismatch_count_i    (mismatch_count_o),
    .saved_steps_i       (saved_steps_o),
    .column_scored_i     (column_scored_o),
    .total_saved_steps_i (total_saved_steps_o),
    .region_last_i       (region_last_o),
    .errors_o            (error_count),
    .pending_o           (pending_columns)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("alignment_column_profile_parsimony_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        stall_phase <= $urandom_range(20, 200);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        StallNone:  out_stall_i <= 1'b0;
        StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
        StallHalf:  out_stall_i <= 1'($urandom_range(0, 1));
        default:    out_stall_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic send_cell(input logic [2:0] code, input logic marked, col_end, reg_end);
    int unsigned idle;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (idle != 0) begin
        in_valid_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    base_code_i  <= code;
    row_marked_i <= marked;
    column_end_i <= col_end;
    region_end_i <= reg_end;
    do @(posedge clk_i); while (in_stall_o);
    cells_sent++;
  endtask

  task automatic send_column(input int unsigned cells, input logic [2:0] lead,
                             input int unsigned lead_pct);
    logic [2:0] code;
    for (int unsigned n = 1; n <= cells; n++) begin
      code = ($urandom_range(1, 100) <= lead_pct) ? lead : 3'($urandom_range(0, 7));
      if (n == cells) begin
        send_cell(code, $urandom_range(0, 7) != 0, 1'b1, $urandom_range(0, 4) == 0);
      end else begin
        send_cell(code, $urandom_range(0, 7) != 0, 1'b0, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  initial begin
    int unsigned cells;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cell(BaseA, 1'b1, 1'b0, 1'b0);
    send_cell(BaseC, 1'b1, 1'b0, 1'b0);
    send_cell(BaseG, 1'b1, 1'b0, 1'b1);
    send_cell(BaseT, 1'b1, 1'b0, 1'b0);
    send_cell(BaseGap, 1'b1, 1'b0, 1'b0);
    send_cell(BaseBlank, 1'b1, 1'b0, 1'b0);
    send_cell(BaseN, 1'b1, 1'b0, 1'b0);
    send_cell(BaseIgn, 1'b1, 1'b1, 1'b0);
    send_cell(BaseG, 1'b0, 1'b1, 1'b0);
    send_cell(BaseT, 1'b0, 1'b0, 1'b0);
    send_cell(BaseG, 1'b1, 1'b0, 1'b0);
    send_cell(BaseG, 1'b1, 1'b0, 1'b0);
    send_cell(BaseC, 1'b1, 1'b0, 1'b0);
    send_cell(BaseG, 1'b1, 1'b0, 1'b0);
    send_cell(BaseC, 1'b1, 1'b1, 1'b1);
    send_cell(BaseGap, 1'b1, 1'b0, 1'b0);
    send_cell(BaseGap, 1'b1, 1'b0, 1'b0);
    send_cell(BaseT, 1'b1, 1'b0, 1'b0);
    send_cell(BaseT, 1'b1, 1'b0, 1'b0);
    send_cell(BaseIgn, 1'b1, 1'b1, 1'b0);
    send_cell(BaseN, 1'b1, 1'b0, 1'b0);
    send_cell(BaseBlank, 1'b1, 1'b0, 1'b0);
    send_cell(BaseA, 1'b1, 1'b1, 1'b1);

    for (int n = 0; n < 260; n++) send_cell(BaseA, 1'b1, n == 259, 1'b0);
    for (int n = 0; n < 380; n++) begin
      send_cell(3'($urandom_range(0, 3)), 1'b1, n == 379, 1'b1);
    end

    while (cells_sent < ItemTarget) begin
      case ($urandom_range(0, 24))
        0:       cells = $urandom_range(30, 80);
        1, 2, 3: cells = $urandom_range(1, 3);
        default: cells = $urandom_range(4, 14);
      endcase
      send_column(cells, 3'($urandom_range(0, 4)), $urandom_range(0, 70));
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_columns != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("alignment_column_profile_parsimony_tb: done, clean");
    end else begin
      $display("alignment_column_profile_parsimony_tb: done, errors");
    end
    $finish;
  end

endmodule
